### rtl/ddpd_pkg.sv
// shared types and constants of the differential drive pd controller
// no dependencies; used by the channel interfaces and the top level
package ddpd_pkg;

	// field widths
	localparam int OP_W      = 2;
	localparam int CNT_W     = 32;
	localparam int PWR_W     = 16;
	localparam int MAXP_W    = 15;
	localparam int GAIN_W    = 32;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [MAXP_W-1:0] MAX_POWER_RST    = 15'h7fff;
	localparam logic [GAIN_W-1:0] MM_PER_CLICK_RST = 32'h0001_0000;

	// turn goal is |deg| * TURN_MUL / TURN_DIV, truncated
	localparam int TURN_MUL = 779;
	localparam int TURN_DIV = 1000;
	localparam int DIVD_W   = 25;
	localparam int REM_W    = 10;

	// serial datapath sizes
	localparam int STEP_W    = 5;
	localparam int MUL1_N    = GAIN_W;
	localparam int ACC1_W    = 19;
	localparam int SUM_W     = ACC1_W + GAIN_W;
	localparam int SAT_W     = 41;
	localparam int MW_W      = 42;
	localparam int DIG_N     = MW_W / 2;
	localparam int ACC2_W    = 16;
	localparam int ROUND_DIG = 7;

	typedef enum logic [OP_W-1:0] {
		OP_RESET = 2'd0,
		OP_FREE  = 2'd1,
		OP_DIST  = 2'd2,
		OP_TURN  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_POWER    = 2'd0,
		CFG_PROP_GAIN    = 2'd1,
		CFG_DERIV_GAIN   = 2'd2,
		CFG_MM_PER_CLICK = 2'd3
	} cfg_idx_t;

	// per-request control decided before the serial passes
	typedef struct packed {
		opcode_t op;
		logic    pd_run;
		logic    early;
		logic    dir_neg;
	} ctl_t;

endpackage

### rtl/ddpd_cmd_if.sv
// request channel of the pd controller: valid/ready plus one control tick
// depends on ddpd_pkg for field widths
interface ddpd_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [ddpd_pkg::OP_W-1:0]           opcode;
	logic signed [ddpd_pkg::CNT_W-1:0]   left_count;
	logic signed [ddpd_pkg::CNT_W-1:0]   right_count;
	logic signed [ddpd_pkg::PWR_W-1:0]   power_a;
	logic signed [ddpd_pkg::PWR_W-1:0]   power_b;
	logic signed [ddpd_pkg::PWR_W-1:0]   target;

	modport source (
		output valid, opcode, left_count, right_count, power_a, power_b, target,
		input  ready
	);
	modport sink (
		input  valid, opcode, left_count, right_count, power_a, power_b, target,
		output ready
	);
endinterface

### rtl/ddpd_res_if.sv
// result channel of the pd controller: valid/ready plus motor commands and done
// depends on ddpd_pkg for field widths
interface ddpd_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [ddpd_pkg::PWR_W-1:0] left_drive;
	logic signed [ddpd_pkg::PWR_W-1:0] right_drive;
	logic                              done_res;

	modport source (
		output valid, left_drive, right_drive, done_res,
		input  ready
	);
	modport sink (
		input  valid, left_drive, right_drive, done_res,
		output ready
	);
endinterface

### rtl/differential_drive_pd_controller_top.sv
// Differential drive pd controller, one request per control tick, one result per request.
// The block works on one request at a time: a new request is taken only once the result of
// the last one has been loaded into the result register. The work is a bit-serial pass over
// the 32-bit gains and the 32-bit mm_per_click register (one bit per step, shared by the pd
// sum, both wheel distances and the turn-goal divider) and a radix-4 pass over the 42-bit
// weight that scales the base power, between the set-up states and the finish state.
// A finished result waits in its own register, so the next request is taken while it waits.
// The user must write the registers through cfg_we/cfg_addr/cfg_wdata only while no request
// is in flight; the block itself does not enforce this.
// depends on ddpd_pkg, ddpd_cmd_if, ddpd_res_if
module differential_drive_pd_controller_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ddpd_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [ddpd_pkg::GAIN_W-1:0]        cfg_wdata,
	ddpd_cmd_if.sink                           cmd,
	ddpd_res_if.source                         res
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PREP1 = 8'b0000_0010,
		ST_PREP2 = 8'b0000_0100,
		ST_MUL1  = 8'b0000_1000,
		ST_SABS  = 8'b0001_0000,
		ST_SW    = 8'b0010_0000,
		ST_MUL2  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [ddpd_pkg::MAXP_W-1:0] max_power_q;
	logic [ddpd_pkg::GAIN_W-1:0] prop_gain_q;
	logic [ddpd_pkg::GAIN_W-1:0] deriv_gain_q;
	logic [ddpd_pkg::GAIN_W-1:0] mm_per_click_q;

	logic signed [15:0] prev_err_q;

	// request fields
	logic [ddpd_pkg::OP_W-1:0] op_q;
	logic signed [31:0]        lc_q;
	logic signed [31:0]        rc_q;
	logic signed [15:0]        pa_q;
	logic signed [15:0]        pb_q;
	logic signed [15:0]        tg_q;

	// set-up values
	logic [31:0]        magl_q;
	logic [31:0]        magr_q;
	logic signed [15:0] cl_q;
	logic signed [15:0] cr_q;
	logic [15:0]        tabs_q;
	ddpd_pkg::ctl_t     ctl_q;
	logic [14:0]        c_q;
	logic signed [15:0] err_q;
	logic signed [16:0] d_q;

	// serial pass one
	logic [31:0]                        pg_sr_q;
	logic [31:0]                        dg_sr_q;
	logic [31:0]                        mpc_sr_q;
	logic signed [ddpd_pkg::ACC1_W-1:0] acc1_q;
	logic [31:0]                        lo1_q;
	logic [31:0]                        mml_acc_q;
	logic [31:0]                        mmr_acc_q;
	logic [31:0]                        mml_lo_q;
	logic [31:0]                        mmr_lo_q;
	logic [ddpd_pkg::DIVD_W-1:0]        x_sr_q;
	logic [ddpd_pkg::REM_W-1:0]         rem_q;
	logic [15:0]                        goal_q;
	logic [ddpd_pkg::STEP_W-1:0]        cnt_q;

	// magnitude, weight and pass two
	logic [ddpd_pkg::SAT_W-1:0]  sabs_q;
	logic                        s_zero_q;
	logic                        s_pos_q;
	logic                        reach_q;
	logic [ddpd_pkg::MW_W-1:0]   mw_sr_q;
	logic                        wneg_q;
	logic [ddpd_pkg::ACC2_W-1:0] acc2_q;
	logic [ddpd_pkg::MW_W-1:0]   lo2_q;

	// result register
	logic               out_valid_q;
	logic signed [15:0] ld_q;
	logic signed [15:0] rd_q;
	logic               done_q;

	function automatic logic signed [15:0] clamp_pwr(input logic signed [15:0] p,
		input logic [14:0] m);
		logic signed [15:0] ms;
		ms = signed'({1'b0, m});
		if (p > ms) begin
			return ms;
		end else if (p < -ms) begin
			return -ms;
		end else begin
			return p;
		end
	endfunction

	logic in_acc;
	logic fin_load;

	assign cmd.ready = (state_q == ST_IDLE);
	assign in_acc    = cmd.valid && cmd.ready;
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || res.ready);

	assign res.valid       = out_valid_q;
	assign res.left_drive  = ld_q;
	assign res.right_drive = rd_q;
	assign res.done_res    = done_q;

	// set-up logic
	logic signed [15:0] err_c;
	logic signed [16:0] d_c;
	logic               early_c;
	logic               pd_free_c;
	logic               pd_run_c;
	logic               dir_neg_c;
	logic [14:0]        c_c;
	logic [ddpd_pkg::DIVD_W-1:0] divd_c;

	always_comb begin
		err_c     = signed'(magl_q[15:0] - magr_q[15:0]);
		d_c       = signed'({prev_err_q[15], prev_err_q} - {err_c[15], err_c});
		early_c   = (tg_q == 16'sd0) || (pa_q == 16'sd0);
		pd_free_c = (cl_q == cr_q) && (cr_q != 16'sd0);
		// in free drive pd only runs with cl == cr, so |cl| is the base power everywhere
		c_c       = cl_q[15] ? 15'(-cl_q) : cl_q[14:0];
		dir_neg_c = (op_q == ddpd_pkg::OP_FREE) ? cr_q[15] : tg_q[15];
		unique case (op_q)
			ddpd_pkg::OP_FREE: pd_run_c = pd_free_c;
			ddpd_pkg::OP_DIST: pd_run_c = !early_c;
			default:           pd_run_c = 1'b0;
		endcase
		divd_c = ddpd_pkg::DIVD_W'(tabs_q) * ddpd_pkg::DIVD_W'(ddpd_pkg::TURN_MUL);
	end

	// pass one, per cycle: one gain bit, one mm_per_click bit, one quotient bit if dividing
	logic signed [ddpd_pkg::ACC1_W:0] add1_c;
	logic [32:0]                      suml_c;
	logic [32:0]                      sumr_c;
	logic [ddpd_pkg::REM_W:0]         trial_c;
	logic                             qbit_c;
	logic                             div_on_c;

	always_comb begin
		add1_c = {acc1_q[ddpd_pkg::ACC1_W-1], acc1_q}
			+ (pg_sr_q[0] ? (ddpd_pkg::ACC1_W+1)'(err_q) : '0)
			+ (dg_sr_q[0] ? (ddpd_pkg::ACC1_W+1)'(d_q) : '0);
		suml_c   = {1'b0, mml_acc_q} + (mpc_sr_q[0] ? {1'b0, magl_q} : 33'd0);
		sumr_c   = {1'b0, mmr_acc_q} + (mpc_sr_q[0] ? {1'b0, magr_q} : 33'd0);
		trial_c  = {rem_q, x_sr_q[ddpd_pkg::DIVD_W-1]};
		qbit_c   = trial_c >= (ddpd_pkg::REM_W+1)'(ddpd_pkg::TURN_DIV);
		div_on_c = (ctl_q.op == ddpd_pkg::OP_TURN)
			&& (cnt_q < ddpd_pkg::STEP_W'(ddpd_pkg::DIVD_W));
	end

	// magnitude of the pd sum, saturated at 2^40, and the distance checks
	logic signed [ddpd_pkg::SUM_W-1:0] s_c;
	logic [ddpd_pkg::SUM_W-1:0]        sabs_full_c;
	logic                              big_c;
	logic [31:0]                       thr_c;
	logic                              reach_c;

	always_comb begin
		s_c         = signed'({acc1_q, lo1_q});
		sabs_full_c = s_c[ddpd_pkg::SUM_W-1] ? ddpd_pkg::SUM_W'(-s_c) : ddpd_pkg::SUM_W'(s_c);
		big_c       = (sabs_full_c[ddpd_pkg::SUM_W-1:41] != '0)
			|| (sabs_full_c[40] && (sabs_full_c[39:0] != 40'd0));
		// round(prod / 2^16) >= goal  <=>  prod >= goal * 2^16 - 2^15
		thr_c   = {goal_q - 16'd1, 16'h8000};
		reach_c = (goal_q == 16'd0)
			|| (mml_acc_q != 32'd0) || (mml_lo_q >= thr_c)
			|| (mmr_acc_q != 32'd0) || (mmr_lo_q >= thr_c);
	end

	// weight of the weaker wheel: 1.0 - |s| in q16.16, kept as sign and magnitude
	logic                       wneg_c;
	logic [16:0]                mw_pos_c;
	logic [ddpd_pkg::SAT_W-1:0] mw_neg_c;

	always_comb begin
		wneg_c   = (sabs_q[ddpd_pkg::SAT_W-1:17] != '0) || (sabs_q[16] && (sabs_q[15:0] != 16'd0));
		mw_pos_c = 17'h1_0000 - sabs_q[16:0];
		mw_neg_c = sabs_q - ddpd_pkg::SAT_W'(17'h1_0000);
	end

	// pass two: radix-4 product c * weight, half a unit added at bit 15 for rounding
	logic [ddpd_pkg::ACC2_W+1:0] add2_c;

	always_comb begin
		add2_c = {2'b00, acc2_q}
			+ (mw_sr_q[0] ? {3'b000, c_q} : 18'd0)
			+ (mw_sr_q[1] ? {2'b00, c_q, 1'b0} : 18'd0)
			+ ((cnt_q == ddpd_pkg::STEP_W'(ddpd_pkg::ROUND_DIG)) ? 18'd2 : 18'd0);
	end

	// result assembly
	logic [ddpd_pkg::ACC2_W+ddpd_pkg::MW_W-17:0] r_c;
	logic               over_c;
	logic [14:0]        wmag_c;
	logic signed [15:0] wk_c;
	logic signed [15:0] wks_c;
	logic signed [15:0] cs_c;
	logic signed [15:0] pdl_c;
	logic signed [15:0] pdr_c;
	logic signed [15:0] l_c;
	logic signed [15:0] r_out_c;
	logic               done_c;

	always_comb begin
		r_c    = {acc2_q, lo2_q[ddpd_pkg::MW_W-1:16]};
		over_c = (r_c[$bits(r_c)-1:15] != '0) || (r_c[14:0] > max_power_q);
		wmag_c = over_c ? max_power_q : r_c[14:0];
		// a positive weight never gives more than c, so only the negative side clamps
		wk_c   = wneg_q ? -signed'({1'b0, wmag_c}) : signed'({1'b0, r_c[14:0]});
		wks_c  = ctl_q.dir_neg ? -wk_c : wk_c;
		cs_c   = ctl_q.dir_neg ? -signed'({1'b0, c_q}) : signed'({1'b0, c_q});
		priority if (s_zero_q) begin
			pdl_c = cs_c;
			pdr_c = cs_c;
		end else if (s_pos_q) begin
			pdl_c = wks_c;
			pdr_c = cs_c;
		end else begin
			pdl_c = cs_c;
			pdr_c = wks_c;
		end
		l_c     = 16'sd0;
		r_out_c = 16'sd0;
		done_c  = 1'b0;
		unique case (ctl_q.op)
			ddpd_pkg::OP_RESET: begin
				done_c = 1'b0;
			end
			ddpd_pkg::OP_FREE: begin
				l_c     = ctl_q.pd_run ? pdl_c : cl_q;
				r_out_c = ctl_q.pd_run ? pdr_c : cr_q;
			end
			ddpd_pkg::OP_DIST: begin
				if (ctl_q.early || reach_q) begin
					done_c = 1'b1;
				end else begin
					l_c     = pdl_c;
					r_out_c = pdr_c;
				end
			end
			ddpd_pkg::OP_TURN: begin
				if (ctl_q.early || reach_q) begin
					done_c = 1'b1;
				end else begin
					l_c     = cs_c;
					r_out_c = -cs_c;
				end
			end
			default: begin
				done_c = 1'b0;
			end
		endcase
	end

	// control state, configuration and the stored error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			ctl_q          <= '0;
			out_valid_q    <= 1'b0;
			prev_err_q     <= 16'sd0;
			max_power_q    <= ddpd_pkg::MAX_POWER_RST;
			prop_gain_q    <= '0;
			deriv_gain_q   <= '0;
			mm_per_click_q <= ddpd_pkg::MM_PER_CLICK_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					ddpd_pkg::CFG_MAX_POWER:    max_power_q    <= cfg_wdata[ddpd_pkg::MAXP_W-1:0];
					ddpd_pkg::CFG_PROP_GAIN:    prop_gain_q    <= cfg_wdata;
					ddpd_pkg::CFG_DERIV_GAIN:   deriv_gain_q   <= cfg_wdata;
					ddpd_pkg::CFG_MM_PER_CLICK: mm_per_click_q <= cfg_wdata;
					default:                    max_power_q    <= max_power_q;
				endcase
			end

			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PREP1;
					end
				end
				ST_PREP1: begin
					state_q <= ST_PREP2;
				end
				ST_PREP2: begin
					ctl_q.op      <= ddpd_pkg::opcode_t'(op_q);
					ctl_q.pd_run  <= pd_run_c;
					ctl_q.early   <= early_c;
					ctl_q.dir_neg <= dir_neg_c;
					if (op_q == ddpd_pkg::OP_RESET) begin
						prev_err_q <= 16'sd0;
					end else if (pd_run_c) begin
						prev_err_q <= err_c;
					end
					cnt_q   <= '0;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ddpd_pkg::STEP_W'(ddpd_pkg::MUL1_N - 1)) begin
						state_q <= ST_SABS;
					end
				end
				ST_SABS: begin
					state_q <= ST_SW;
				end
				ST_SW: begin
					cnt_q   <= '0;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ddpd_pkg::STEP_W'(ddpd_pkg::DIG_N - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= cmd.opcode;
			lc_q <= cmd.left_count;
			rc_q <= cmd.right_count;
			pa_q <= cmd.power_a;
			pb_q <= cmd.power_b;
			tg_q <= cmd.target;
		end

		if (state_q == ST_PREP1) begin
			magl_q <= lc_q[31] ? 32'(-lc_q) : 32'(lc_q);
			magr_q <= rc_q[31] ? 32'(-rc_q) : 32'(rc_q);
			cl_q   <= clamp_pwr(pa_q, max_power_q);
			cr_q   <= clamp_pwr(pb_q, max_power_q);
			tabs_q <= tg_q[15] ? 16'(-tg_q) : 16'(tg_q);
		end

		if (state_q == ST_PREP2) begin
			err_q     <= err_c;
			d_q       <= d_c;
			c_q       <= c_c;
			pg_sr_q   <= prop_gain_q;
			dg_sr_q   <= deriv_gain_q;
			mpc_sr_q  <= mm_per_click_q;
			acc1_q    <= '0;
			mml_acc_q <= '0;
			mmr_acc_q <= '0;
			x_sr_q    <= divd_c;
			rem_q     <= '0;
			goal_q    <= (op_q == ddpd_pkg::OP_TURN) ? 16'd0 : tabs_q;
		end

		if (state_q == ST_MUL1) begin
			pg_sr_q   <= pg_sr_q >> 1;
			dg_sr_q   <= dg_sr_q >> 1;
			mpc_sr_q  <= mpc_sr_q >> 1;
			acc1_q    <= add1_c[ddpd_pkg::ACC1_W:1];
			lo1_q     <= {add1_c[0], lo1_q[31:1]};
			mml_acc_q <= suml_c[32:1];
			mml_lo_q  <= {suml_c[0], mml_lo_q[31:1]};
			mmr_acc_q <= sumr_c[32:1];
			mmr_lo_q  <= {sumr_c[0], mmr_lo_q[31:1]};
			if (div_on_c) begin
				x_sr_q <= x_sr_q << 1;
				rem_q  <= qbit_c
					? ddpd_pkg::REM_W'(trial_c - (ddpd_pkg::REM_W+1)'(ddpd_pkg::TURN_DIV))
					: trial_c[ddpd_pkg::REM_W-1:0];
				goal_q <= {goal_q[14:0], qbit_c};
			end
		end

		if (state_q == ST_SABS) begin
			sabs_q   <= big_c ? {1'b1, 40'd0} : sabs_full_c[ddpd_pkg::SAT_W-1:0];
			s_zero_q <= (s_c == '0);
			s_pos_q  <= !s_c[ddpd_pkg::SUM_W-1];
			reach_q  <= reach_c;
		end

		if (state_q == ST_SW) begin
			wneg_q  <= wneg_c;
			mw_sr_q <= wneg_c ? {1'b0, mw_neg_c} : {25'd0, mw_pos_c};
			acc2_q  <= '0;
		end

		if (state_q == ST_MUL2) begin
			mw_sr_q <= mw_sr_q >> 2;
			acc2_q  <= add2_c[ddpd_pkg::ACC2_W+1:2];
			lo2_q   <= {add2_c[1:0], lo2_q[ddpd_pkg::MW_W-1:2]};
		end

		if (fin_load) begin
			ld_q   <= l_c;
			rd_q   <= r_out_c;
			done_q <= done_c;
		end
	end

endmodule
